[src/assert_macros.svh]
// assertion macros used by the top-level rtl file of the collision block
// no dependencies; empty bodies under SYNTHESIS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication under synchronous active-low reset
`define ECP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under synchronous active-low reset
`define ECP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ECP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ECP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[src/ecp_pkg.sv]
// shared widths and helpers for the elastic collision pipeline
// no dependencies
package ecp_pkg;

  localparam int VEL_W  = 32;
  localparam int MASS_W = 32;
  localparam int RAD_W  = 31;
  localparam int DIFF_W = 33;
  localparam int MAG_W  = 33;
  localparam int SQ_W   = 66;
  localparam int D2_W   = 66;
  localparam int DOT_W  = 67;
  localparam int DOTM_W = 66;
  localparam int MSUM_W = 33;
  localparam int RSUM_W = 32;
  localparam int QUO_W  = 35;
  localparam int CHG_W  = 36;
  localparam int LANES  = 4;

  // clamp a widened velocity sum to the signed 32 bit range
  function automatic logic [VEL_W-1:0] sat_vel(input logic [CHG_W:0] x);
    logic [VEL_W-1:0] res;
    if (!x[CHG_W] && (|x[CHG_W-1:VEL_W-1])) begin
      res = {1'b0, {(VEL_W-1){1'b1}}};
    end else if (x[CHG_W] && !(&x[CHG_W-1:VEL_W-1])) begin
      res = {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      res = x[VEL_W-1:0];
    end
    return res;
  endfunction

endpackage

[src/elastic_collision_2d_pair_top.sv]
// two-particle elastic impact pipeline: hit test and post-impact velocities
// depends on ecp_pkg, ecp_div_pipe and assert_macros.svh
//
//   port group  dir  handshake           payload
//   in_*        in   in_valid/in_stall   centers, velocities, masses, radii
//   out_*       out  out_valid/out_stall hit, degenerate, four new velocities
//
// one beat enters every cycle while in_stall is low; the pipeline depth is set by the
// mass-factor divider (FRAC_BITS + 2 stages) and the impulse divider (35 stages)
// rst_n is synchronous and clears only the valid bits
// the whole pipeline advances together; it freezes only while a result beat
// sits in the output register and out_stall is high
`include "assert_macros.svh"

module elastic_collision_2d_pair_top
  import ecp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [VEL_W-1:0]  in_pos_a_x,
  input  logic [VEL_W-1:0]  in_pos_a_y,
  input  logic [VEL_W-1:0]  in_pos_b_x,
  input  logic [VEL_W-1:0]  in_pos_b_y,
  input  logic [VEL_W-1:0]  in_vel_a_x,
  input  logic [VEL_W-1:0]  in_vel_a_y,
  input  logic [VEL_W-1:0]  in_vel_b_x,
  input  logic [VEL_W-1:0]  in_vel_b_y,
  input  logic [MASS_W-1:0] in_mass_a,
  input  logic [MASS_W-1:0] in_mass_b,
  input  logic [RAD_W-1:0]  in_radius_a,
  input  logic [RAD_W-1:0]  in_radius_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_hit,
  output logic              out_degenerate,
  output logic [VEL_W-1:0]  out_new_vel_a_x,
  output logic [VEL_W-1:0]  out_new_vel_a_y,
  output logic [VEL_W-1:0]  out_new_vel_b_x,
  output logic [VEL_W-1:0]  out_new_vel_b_y
);

  // mass factor 2m/(mA+mB) carries FRAC_BITS fraction bits, at most 2.0
  localparam int ALPHA_W = FRAC_BITS + 2;
  localparam int ANUM_W  = MSUM_W + FRAC_BITS;
  // alpha * |d_c| and the full impulse numerator
  localparam int PROD_W  = ALPHA_W + MAG_W;
  localparam int NUM_W   = DOTM_W + PROD_W;
  // |d|^2 scaled by the fraction bits
  localparam int DEN_W   = D2_W + FRAC_BITS;
  // main path waits here for the mass factors
  localparam int DLY     = FRAC_BITS - 1;
  localparam int LAT     = ALPHA_W + QUO_W + 6;

  typedef struct packed {
    logic [LANES-1:0][VEL_W-1:0] vel;
    logic                        hit;
    logic                        degen;
    logic                        dotneg;
    logic                        mz;
    logic                        sdx;
    logic                        sdy;
    logic [MAG_W-1:0]            adx;
    logic [MAG_W-1:0]            ady;
    logic [DOTM_W-1:0]           dotm;
    logic [DEN_W-1:0]            den;
  } main_t;

  typedef struct packed {
    logic [LANES-1:0][VEL_W-1:0] vel;
    logic                        hit;
    logic                        degen;
    logic                        dotneg;
    logic                        sdx;
    logic                        sdy;
  } side_t;

  logic           adv;
  logic [LAT-1:0] vld_r;

  // global advance: a waiting output beat holds every stage in place
  assign adv       = !vld_r[LAT-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // stage 1: differences, radius sum, mass sum
  logic signed [DIFF_W-1:0]    dx_r, dy_r, dvx_r, dvy_r;
  logic [RSUM_W-1:0]           rsum_r;
  logic [MSUM_W-1:0]           msum_r;
  logic [MASS_W-1:0]           ma_r, mb_r;
  logic [LANES-1:0][VEL_W-1:0] vel1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r   <= {in_pos_b_x[VEL_W-1], in_pos_b_x} - {in_pos_a_x[VEL_W-1], in_pos_a_x};
      dy_r   <= {in_pos_b_y[VEL_W-1], in_pos_b_y} - {in_pos_a_y[VEL_W-1], in_pos_a_y};
      dvx_r  <= {in_vel_b_x[VEL_W-1], in_vel_b_x} - {in_vel_a_x[VEL_W-1], in_vel_a_x};
      dvy_r  <= {in_vel_b_y[VEL_W-1], in_vel_b_y} - {in_vel_a_y[VEL_W-1], in_vel_a_y};
      rsum_r <= {1'b0, in_radius_a} + {1'b0, in_radius_b};
      msum_r <= {1'b0, in_mass_a} + {1'b0, in_mass_b};
      ma_r   <= in_mass_a;
      mb_r   <= in_mass_b;
      vel1_r <= {in_vel_b_y, in_vel_b_x, in_vel_a_y, in_vel_a_x};
    end
  end

  // mass factors: (2m << FRAC_BITS) / (mA + mB)
  logic [ANUM_W-1:0]  anum_a, anum_b;
  logic [ALPHA_W-1:0] aq_a, aq_b;
  logic [ALPHA_W-1:0] alpha_a, alpha_b;

  assign anum_a = {ma_r, 1'b0, {FRAC_BITS{1'b0}}};
  assign anum_b = {mb_r, 1'b0, {FRAC_BITS{1'b0}}};

  ecp_div_pipe #(.QW(ALPHA_W), .DW(MSUM_W)) u_adiv_a (
    .clk   (clk),
    .en    (adv),
    .rem_i ({2'b00, anum_a[ANUM_W-1:ALPHA_W]}),
    .low_i (anum_a[ALPHA_W-1:0]),
    .den_i (msum_r),
    .quo_o (aq_a)
  );

  ecp_div_pipe #(.QW(ALPHA_W), .DW(MSUM_W)) u_adiv_b (
    .clk   (clk),
    .en    (adv),
    .rem_i ({2'b00, anum_b[ANUM_W-1:ALPHA_W]}),
    .low_i (anum_b[ALPHA_W-1:0]),
    .den_i (msum_r),
    .quo_o (aq_b)
  );

  // stage 2: squares, dot terms, radius square
  logic signed [SQ_W-1:0]      sqx_r, sqy_r, pdx_r, pdy_r;
  logic [2*RSUM_W-1:0]         rr2_r;
  logic                        degen2_r, mz2_r;
  logic [MAG_W-1:0]            adx2_r, ady2_r;
  logic                        sdx2_r, sdy2_r;
  logic [LANES-1:0][VEL_W-1:0] vel2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r    <= dx_r * dx_r;
      sqy_r    <= dy_r * dy_r;
      pdx_r    <= dvx_r * dx_r;
      pdy_r    <= dvy_r * dy_r;
      rr2_r    <= rsum_r * rsum_r;
      degen2_r <= (dx_r == '0) && (dy_r == '0);
      mz2_r    <= (msum_r == '0);
      adx2_r   <= dx_r[DIFF_W-1] ? (~dx_r + 33'd1) : dx_r;
      ady2_r   <= dy_r[DIFF_W-1] ? (~dy_r + 33'd1) : dy_r;
      sdx2_r   <= dx_r[DIFF_W-1];
      sdy2_r   <= dy_r[DIFF_W-1];
      vel2_r   <= vel1_r;
    end
  end

  // stage 3: |d|^2 and dv . d
  logic [D2_W-1:0]             d2_r;
  logic [DOT_W-1:0]            dot_r;
  logic [2*RSUM_W-1:0]         rr3_r;
  logic                        degen3_r, mz3_r, sdx3_r, sdy3_r;
  logic [MAG_W-1:0]            adx3_r, ady3_r;
  logic [LANES-1:0][VEL_W-1:0] vel3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      // squares are never negative, so the sum is taken unsigned
      d2_r     <= sqx_r + sqy_r;
      dot_r    <= {pdx_r[SQ_W-1], pdx_r} + {pdy_r[SQ_W-1], pdy_r};
      rr3_r    <= rr2_r;
      degen3_r <= degen2_r;
      mz3_r    <= mz2_r;
      sdx3_r   <= sdx2_r;
      sdy3_r   <= sdy2_r;
      adx3_r   <= adx2_r;
      ady3_r   <= ady2_r;
      vel3_r   <= vel2_r;
    end
  end

  // stage 4: hit compare, dot magnitude, scaled divisor
  logic [DOT_W-1:0] dot_neg;
  main_t            s4_r;

  assign dot_neg = ~dot_r + 67'd1;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_r.vel    <= vel3_r;
      s4_r.hit    <= {2'b00, rr3_r} >= d2_r;
      s4_r.degen  <= degen3_r;
      s4_r.dotneg <= dot_r[DOT_W-1];
      s4_r.mz     <= mz3_r;
      s4_r.sdx    <= sdx3_r;
      s4_r.sdy    <= sdy3_r;
      s4_r.adx    <= adx3_r;
      s4_r.ady    <= ady3_r;
      s4_r.dotm   <= dot_r[DOT_W-1] ? dot_neg[DOTM_W-1:0] : dot_r[DOTM_W-1:0];
      s4_r.den    <= {d2_r, {FRAC_BITS{1'b0}}};
    end
  end

  // hold the main path until the mass factors arrive
  main_t dly_r [DLY];

  always_ff @(posedge clk) begin
    if (adv) begin
      dly_r[0] <= s4_r;
      for (int i = 1; i < DLY; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  // both masses zero: no impulse at all
  assign alpha_a = dly_r[DLY-1].mz ? '0 : aq_a;
  assign alpha_b = dly_r[DLY-1].mz ? '0 : aq_b;

  // lanes: A.x, A.y use alpha_b; B.x, B.y use alpha_a
  main_t             m1_r, m2_r, m3_r, m4_r;
  logic [PROD_W-1:0] pm_r [LANES];
  logic [NUM_W-1:0]  ll_r [LANES];
  logic [NUM_W-1:0]  lh_r [LANES];
  logic [NUM_W-1:0]  hl_r [LANES];
  logic [NUM_W-1:0]  hh_r [LANES];
  logic [NUM_W-1:0]  lo_r [LANES];
  logic [NUM_W-1:0]  hi_r [LANES];
  logic [NUM_W-1:0]  num_r [LANES];
  logic [QUO_W-1:0]  quo [LANES];

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r <= dly_r[DLY-1];
      m2_r <= m1_r;
      m3_r <= m2_r;
      m4_r <= m3_r;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [ALPHA_W-1:0] alpha;
    logic [MAG_W-1:0]   mag;
    logic [NUM_W-1:0]   ll, lh, hl, hh;

    assign alpha = (l < 2) ? alpha_b : alpha_a;
    assign mag   = (l % 2 == 0) ? dly_r[DLY-1].adx : dly_r[DLY-1].ady;

    // 66 x PROD_W split into four partial products
    assign ll = m1_r.dotm[32:0] * pm_r[l][31:0];
    assign lh = m1_r.dotm[32:0] * pm_r[l][PROD_W-1:32];
    assign hl = m1_r.dotm[DOTM_W-1:33] * pm_r[l][31:0];
    assign hh = m1_r.dotm[DOTM_W-1:33] * pm_r[l][PROD_W-1:32];

    always_ff @(posedge clk) begin
      if (adv) begin
        pm_r[l]  <= alpha * mag;
        ll_r[l]  <= ll;
        lh_r[l]  <= lh;
        hl_r[l]  <= hl;
        hh_r[l]  <= hh;
        lo_r[l]  <= ll_r[l] + (lh_r[l] << 32);
        hi_r[l]  <= hl_r[l] + (hh_r[l] << 32);
        num_r[l] <= lo_r[l] + (hi_r[l] << 33);
      end
    end

    ecp_div_pipe #(.QW(QUO_W), .DW(DEN_W)) u_div (
      .clk   (clk),
      .en    (adv),
      .rem_i (num_r[l][NUM_W-1:QUO_W]),
      .low_i (num_r[l][QUO_W-1:0]),
      .den_i (m4_r.den),
      .quo_o (quo[l])
    );
  end

  // flags and velocities ride alongside the impulse divider
  side_t side_r [QUO_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0].vel    <= m4_r.vel;
      side_r[0].hit    <= m4_r.hit;
      side_r[0].degen  <= m4_r.degen;
      side_r[0].dotneg <= m4_r.dotneg;
      side_r[0].sdx    <= m4_r.sdx;
      side_r[0].sdy    <= m4_r.sdy;
      for (int i = 1; i < QUO_W; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // output stage: signed change, add or subtract, saturate
  side_t                       fin;
  logic                        apply;
  logic [LANES-1:0][VEL_W-1:0] nv;

  assign fin   = side_r[QUO_W-1];
  assign apply = fin.hit && !fin.degen;

  for (genvar l = 0; l < LANES; l++) begin : g_fin
    logic           neg;
    logic [CHG_W:0] q_ext;
    logic [CHG_W:0] chg;
    logic [CHG_W:0] v_ext;
    logic [CHG_W:0] sum;

    assign neg   = fin.dotneg != ((l % 2 == 0) ? fin.sdx : fin.sdy);
    assign q_ext = {2'b00, quo[l]};
    assign chg   = neg ? (~q_ext + 37'd1) : q_ext;
    assign v_ext = {{(CHG_W+1-VEL_W){fin.vel[l][VEL_W-1]}}, fin.vel[l]};
    assign sum   = (l < 2) ? (v_ext + chg) : (v_ext - chg);
    assign nv[l] = apply ? sat_vel(sum) : fin.vel[l];
  end

  logic             hit_r, degen_r;
  logic [VEL_W-1:0] nvax_r, nvay_r, nvbx_r, nvby_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r   <= fin.hit;
      degen_r <= fin.degen;
      nvax_r  <= nv[0];
      nvay_r  <= nv[1];
      nvbx_r  <= nv[2];
      nvby_r  <= nv[3];
    end
  end

  assign out_hit         = hit_r;
  assign out_degenerate  = degen_r;
  assign out_new_vel_a_x = nvax_r;
  assign out_new_vel_a_y = nvay_r;
  assign out_new_vel_b_x = nvbx_r;
  assign out_new_vel_b_y = nvby_r;

  `ECP_ASSERT_IMP(a_degen_is_hit, clk, rst_n, vld_r[LAT-1] && degen_r, hit_r, "degen without hit")
  `ECP_ASSERT_NXT(a_beat_enters, clk, rst_n, in_valid && !in_stall, vld_r[0], "beat lost at entry")
  `ECP_ASSERT_IMP(a_zero_mass, clk, rst_n, dly_r[DLY-1].mz, ~|{alpha_a, alpha_b}, "alpha not zero")

endmodule

[src/ecp_div_pipe.sv]
// pipelined restoring divider, one quotient bit per stage
// standalone; the caller keeps valid bits and guarantees rem_i < den_i
module ecp_div_pipe #(
  parameter int QW = 35,
  parameter int DW = 82
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] low_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] l_in;
    logic [QW-1:0] q_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_head
      assign r_in = rem_i;
      assign d_in = den_i;
      assign l_in = low_i;
      assign q_in = '0;
    end else begin : g_body
      assign r_in = rem_r[k-1];
      assign d_in = den_r[k-1];
      assign l_in = low_r[k-1];
      assign q_in = quo_r[k-1];
    end

    // shift in the next numerator bit and try a subtract
    assign trial = {r_in, l_in[QW-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        den_r[k] <= d_in;
        low_r[k] <= {l_in[QW-2:0], 1'b0};
        quo_r[k] <= {q_in[QW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_r[QW-1];

endmodule

[tb/tb_elastic_collision_2d_pair_top.sv]
// self-checking testbench for the two-particle elastic impact pipeline
// depends on ecp_pkg and elastic_collision_2d_pair_top; predicts results in wide integers unless a row carries its own
`timescale 1ns / 1ps

module tb_elastic_collision_2d_pair_top;
  import ecp_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int PIPE_LAT  = FRAC_BITS + 43;
  localparam int IDLE_LIMIT = 5000;
  localparam int N_RANDOM  = 440;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [30:0] R_ONE = 31'h0001_0000;
  localparam logic [31:0] S_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] pos_a_x, pos_a_y, pos_b_x, pos_b_y;
    logic [31:0] vel_a_x, vel_a_y, vel_b_x, vel_b_y;
    logic [31:0] mass_a, mass_b;
    logic [30:0] radius_a, radius_b;
  } pair_t;

  typedef struct packed {
    logic        hit, degenerate;
    logic [31:0] vax, vay, vbx, vby;
  } impact_t;

  // one row of the directed table; typed rows carry their own expected beat
  typedef struct packed {
    pair_t   pair;
    logic    typed;
    impact_t want;
  } row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [31:0]       in_pos_a_x, in_pos_a_y, in_pos_b_x, in_pos_b_y;
  logic [31:0]       in_vel_a_x, in_vel_a_y, in_vel_b_x, in_vel_b_y;
  logic [31:0]       in_mass_a, in_mass_b;
  logic [30:0]       in_radius_a, in_radius_b;
  logic              out_valid;
  logic              out_stall;
  logic              out_hit, out_degenerate;
  logic [31:0]       out_new_vel_a_x, out_new_vel_a_y, out_new_vel_b_x, out_new_vel_b_y;

  impact_t pending_impacts[$];
  int      mismatches;
  int      idle_cycles;
  bit      hold_request;

  elastic_collision_2d_pair_top #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_a_x(in_pos_a_x), .in_pos_a_y(in_pos_a_y),
    .in_pos_b_x(in_pos_b_x), .in_pos_b_y(in_pos_b_y),
    .in_vel_a_x(in_vel_a_x), .in_vel_a_y(in_vel_a_y),
    .in_vel_b_x(in_vel_b_x), .in_vel_b_y(in_vel_b_y),
    .in_mass_a(in_mass_a), .in_mass_b(in_mass_b),
    .in_radius_a(in_radius_a), .in_radius_b(in_radius_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hit(out_hit), .out_degenerate(out_degenerate),
    .out_new_vel_a_x(out_new_vel_a_x), .out_new_vel_a_y(out_new_vel_a_y),
    .out_new_vel_b_x(out_new_vel_b_x), .out_new_vel_b_y(out_new_vel_b_y)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // clamp a wide signed velocity to the 32 bit range
  function automatic logic [31:0] clamp_vel(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return S_MAX;
    if (v < -128'sd2147483648) return S_MIN;
    return v[31:0];
  endfunction

  // velocity change along one axis: dc * dot * factor / (|d|^2 << FRAC_BITS), toward zero
  function automatic logic signed [127:0] axis_impulse(input logic signed [127:0] dc,
      input logic [127:0] dot_mag, input logic dot_neg, input logic [127:0] factor,
      input logic [127:0] denom);
    logic [127:0]        dc_mag;
    logic [127:0]        quot;
    logic signed [127:0] m;
    dc_mag = dc[127] ? -dc : dc;
    quot   = (dot_mag * factor * dc_mag) / denom;
    m      = {65'b0, quot[62:0]};
    return (dot_neg != dc[127]) ? -m : m;
  endfunction

  function automatic impact_t predict_impact(input pair_t p);
    logic signed [127:0] pax, pay, pbx, pby, vax, vay, vbx, vby;
    logic signed [127:0] dx, dy, dvx, dvy, d2, dot;
    logic [127:0]        rr, dot_mag, denom, msum, fac_a, fac_b;
    logic [31:0]         rsum;
    logic                dot_neg;
    impact_t             r;
    pax = $signed(p.pos_a_x); pay = $signed(p.pos_a_y);
    pbx = $signed(p.pos_b_x); pby = $signed(p.pos_b_y);
    vax = $signed(p.vel_a_x); vay = $signed(p.vel_a_y);
    vbx = $signed(p.vel_b_x); vby = $signed(p.vel_b_y);
    dx = pbx - pax;
    dy = pby - pay;
    d2 = dx * dx + dy * dy;
    rsum = {1'b0, p.radius_a} + {1'b0, p.radius_b};
    rr = 128'(rsum) * 128'(rsum);
    r.hit = (rr >= 128'(d2));
    r.degenerate = (dx == 0) && (dy == 0);
    if (r.hit && !r.degenerate) begin
      dvx = vbx - vax;
      dvy = vby - vay;
      dot = dvx * dx + dvy * dy;
      dot_neg = dot[127];
      dot_mag = dot_neg ? -dot : dot;
      msum = 128'(p.mass_a) + 128'(p.mass_b);
      fac_a = 0;
      fac_b = 0;
      if (msum != 0) begin
        fac_b = (128'(p.mass_b) << (FRAC_BITS + 1)) / msum;
        fac_a = (128'(p.mass_a) << (FRAC_BITS + 1)) / msum;
      end
      denom = 128'(d2) << FRAC_BITS;
      vax = vax + axis_impulse(dx, dot_mag, dot_neg, fac_b, denom);
      vay = vay + axis_impulse(dy, dot_mag, dot_neg, fac_b, denom);
      vbx = vbx - axis_impulse(dx, dot_mag, dot_neg, fac_a, denom);
      vby = vby - axis_impulse(dy, dot_mag, dot_neg, fac_a, denom);
    end
    r.vax = clamp_vel(vax);
    r.vay = clamp_vel(vay);
    r.vbx = clamp_vel(vbx);
    r.vby = clamp_vel(vby);
    return r;
  endfunction

  function automatic pair_t make_pair(input logic [31:0] pax, pay, pbx, pby,
      vax, vay, vbx, vby, ma, mb, input logic [30:0] ra, rb);
    pair_t p;
    p = '{pax, pay, pbx, pby, vax, vay, vbx, vby, ma, mb, ra, rb};
    return p;
  endfunction

  // velocities unchanged, flags as given
  function automatic impact_t pass_through(input pair_t p, input logic h, input logic dg);
    impact_t r;
    r = '{h, dg, p.vel_a_x, p.vel_a_y, p.vel_b_x, p.vel_b_y};
    return r;
  endfunction

  // random pair; most are shaped to touch so the impulse path gets exercised
  function automatic pair_t random_pair();
    pair_t p;
    int    span;
    p = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, 31'($urandom), 31'($urandom));
    if ($urandom_range(0, 9) < 7) begin
      span = 1 << $urandom_range(4, 26);
      p.pos_b_x  = p.pos_a_x + $urandom_range(0, span) - span / 2;
      p.pos_b_y  = p.pos_a_y + $urandom_range(0, span) - span / 2;
      p.radius_a = 31'($urandom_range(0, span));
      p.radius_b = 31'($urandom_range(0, span));
      if ($urandom_range(0, 1)) begin
        p.vel_a_x = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        p.vel_a_y = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        p.vel_b_x = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        p.vel_b_y = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      end
      if ($urandom_range(0, 2) == 0) begin
        p.mass_a = $urandom_range(1, 1 << 20);
        p.mass_b = $urandom_range(1, 1 << 20);
      end
    end
    if (p.mass_a == 0) p.mass_a = 1;
    if (p.mass_b == 0) p.mass_b = 1;
    return p;
  endfunction

  // offer one beat and hold it until accepted
  task automatic send_pair(input pair_t p, input logic typed, input impact_t want);
    @(negedge clk);
    in_valid <= 1'b1;
    {in_pos_a_x, in_pos_a_y, in_pos_b_x, in_pos_b_y, in_vel_a_x, in_vel_a_y,
     in_vel_b_x, in_vel_b_y, in_mass_a, in_mass_b, in_radius_a, in_radius_b} <= p;
    do @(posedge clk); while (in_stall);
    pending_impacts.push_back(typed ? want : predict_impact(p));
  endtask

  task automatic sender_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // result checker: compare each accepted beat with the oldest prediction
  always @(posedge clk) begin
    impact_t want, got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_hit, out_degenerate, out_new_vel_a_x, out_new_vel_a_y,
              out_new_vel_b_x, out_new_vel_b_y};
      if (pending_impacts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        want = pending_impacts.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: hit %b/%b degen %b/%b va %h,%h/%h,%h vb %h,%h/%h,%h",
                     $realtime, want.hit, got.hit, want.degenerate, got.degenerate,
                     want.vax, want.vay, got.vax, got.vay,
                     want.vbx, want.vby, got.vbx, got.vby);
        end
      end
    end
  end

  // watchdog: cycles in which neither side moves a beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver: mode changes every so often; a long hold-off on request fills the pipe
  initial begin
    int mode;
    out_stall = 1'b0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (3 * PIPE_LAT + 100) @(negedge clk);
      end
      if ($urandom_range(0, 150) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 9) < 3);
        end
        default: begin
          out_stall <= ($urandom_range(0, 9) < 8);
        end
      endcase
    end
  end

  // stimulus
  initial begin
    row_t  rows[$];
    row_t  r;
    pair_t p;
    int    sent;
    in_valid = 1'b0;
    {in_pos_a_x, in_pos_a_y, in_pos_b_x, in_pos_b_y, in_vel_a_x, in_vel_a_y,
     in_vel_b_x, in_vel_b_y, in_mass_a, in_mass_b, in_radius_a, in_radius_b} = '0;
    hold_request = 1'b0;
    mismatches = 0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // coincident centers: degenerate, velocities untouched
    p = make_pair(0, 0, 0, 0, 5, 6, 7, 8, Q_ONE, Q_ONE, 0, 0);
    rows.push_back('{p, 1'b1, pass_through(p, 1'b1, 1'b1)});
    p = make_pair(S_MAX, S_MIN, S_MAX, S_MIN, S_MIN, S_MAX, S_MAX, S_MIN,
                  32'hffff_ffff, 1, 31'h7fff_ffff, 31'h7fff_ffff);
    rows.push_back('{p, 1'b1, pass_through(p, 1'b1, 1'b1)});
    // well apart: no hit
    p = make_pair(0, 0, 100 * Q_ONE, 0, Q_ONE, 0, -Q_ONE, 0, Q_ONE, Q_ONE, R_ONE, R_ONE);
    rows.push_back('{p, 1'b1, pass_through(p, 1'b0, 1'b0)});
    // opposite corners with largest radii still miss
    p = make_pair(S_MIN, S_MIN, S_MAX, S_MAX, 1, 2, 3, 4, 1, 1, 31'h7fff_ffff, 31'h7fff_ffff);
    rows.push_back('{p, 1'b1, pass_through(p, 1'b0, 1'b0)});
    // largest radii exactly touching across the whole range
    p = make_pair(S_MIN, 0, S_MAX - 1, 0, S_MAX, S_MIN, S_MIN, S_MAX,
                  Q_ONE, Q_ONE, 31'h7fff_ffff, 31'h7fff_ffff);
    rows.push_back('{p, 1'b0, impact_t'(0)});
    // head-on equal masses, just touching
    p = make_pair(0, 0, 2 * Q_ONE, 0, Q_ONE, 0, -Q_ONE, 0, Q_ONE, Q_ONE, R_ONE, R_ONE);
    rows.push_back('{p, 1'b0, impact_t'(0)});
    // one unit short of touching
    p = make_pair(0, 0, 2 * Q_ONE + 1, 0, Q_ONE, 0, -Q_ONE, 0, Q_ONE, Q_ONE, R_ONE, R_ONE);
    rows.push_back('{p, 1'b1, pass_through(p, 1'b0, 1'b0)});
    // glancing diagonal with saturating velocities
    p = make_pair(0, 0, Q_ONE, Q_ONE, S_MAX, S_MAX, S_MIN, S_MIN, Q_ONE, Q_ONE, R_ONE, R_ONE);
    rows.push_back('{p, 1'b0, impact_t'(0)});
    p = make_pair(0, 0, 1, 0, S_MIN, S_MAX, S_MAX, S_MIN, 1, 32'hffff_ffff, 1, 0);
    rows.push_back('{p, 1'b0, impact_t'(0)});
    // mass extremes both ways
    p = make_pair(Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, 3 * Q_ONE, 0, 0, -Q_ONE,
                  32'hffff_ffff, 32'hffff_ffff, 2 * R_ONE, 0);
    rows.push_back('{p, 1'b0, impact_t'(0)});
    p = make_pair(Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, 3 * Q_ONE, 0, 0, -Q_ONE,
                  32'hffff_ffff, 1, 2 * R_ONE, R_ONE);
    rows.push_back('{p, 1'b0, impact_t'(0)});
    // both masses zero: a hit leaves velocities alone
    p = make_pair(0, 0, Q_ONE, 0, Q_ONE, 0, -Q_ONE, 0, 0, 0, R_ONE, R_ONE);
    rows.push_back('{p, 1'b1, pass_through(p, 1'b1, 1'b0)});
    // a single zero mass: massless particle takes the whole exchange
    p = make_pair(0, 0, Q_ONE, Q_ONE, Q_ONE, 0, -Q_ONE, 0, 0, Q_ONE, R_ONE, R_ONE);
    rows.push_back('{p, 1'b0, impact_t'(0)});
    p = make_pair(0, 0, Q_ONE, Q_ONE, Q_ONE, 0, -Q_ONE, 0, Q_ONE, 0, R_ONE, R_ONE);
    rows.push_back('{p, 1'b0, impact_t'(0)});
    // separating pair that still overlaps
    p = make_pair(0, 0, Q_ONE, 0, -Q_ONE, 0, Q_ONE, 0, Q_ONE, 2 * Q_ONE, R_ONE, R_ONE);
    rows.push_back('{p, 1'b0, impact_t'(0)});

    foreach (rows[i]) begin
      r = rows[i];
      send_pair(r.pair, r.typed, r.want);
    end
    sender_gap(1);

    // hold until the directed beats have drained
    while (pending_impacts.size() != 0) @(posedge clk);

    sent = 0;
    while (sent < N_RANDOM) begin
      int burst;
      burst = $urandom_range(1, 24);
      // long receiver hold-off while the sender keeps offering
      if (sent >= N_RANDOM / 2 && sent < N_RANDOM / 2 + 24 && !hold_request)
        hold_request = 1'b1;
      repeat (burst) begin
        if (sent < N_RANDOM) begin
          send_pair(random_pair(), 1'b0, impact_t'(0));
          sent++;
        end
      end
      if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 10));
    end
    sender_gap(1);

    while (pending_impacts.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 40) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
